// ===== rtl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and codes of the thread table scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int SLOT_COUNT_DEF = 64;

    // event codes
    localparam logic [2:0] ACT_CREATE = 3'd0;
    localparam logic [2:0] ACT_SCHED  = 3'd1;
    localparam logic [2:0] ACT_BLOCK  = 3'd2;
    localparam logic [2:0] ACT_WAKE   = 3'd3;
    localparam logic [2:0] ACT_EXIT   = 3'd4;
    localparam logic [2:0] ACT_JOIN   = 3'd5;

    // result status codes
    localparam logic [1:0] RS_OK      = 2'd0;
    localparam logic [1:0] RS_FULL    = 2'd1;
    localparam logic [1:0] RS_IGNORED = 2'd2;
    localparam logic [1:0] RS_NOTDEAD = 2'd3;

    // slot states
    localparam logic [1:0] SS_DEAD    = 2'd0;
    localparam logic [1:0] SS_READY   = 2'd1;
    localparam logic [1:0] SS_RUNNING = 2'd2;
    localparam logic [1:0] SS_BLOCKED = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_CUR_CHK,
        S_TGT_CHK,
        S_RS_RD,
        S_RS_CHK,
        S_DEQ,
        S_DEQ_LINK,
        S_POST_RD,
        S_POST_CHK,
        S_OUT
    } state_t;

    // result beat, status in the lowest bits
    typedef struct packed {
        logic [1:0]         slot_state;
        logic signed [31:0] join_code;
        logic [31:0]        slot_id;
        logic [5:0]         slot_index;
        logic [5:0]         previous_index;
        logic               switched;
        logic [5:0]         current_index;
        logic               current_valid;
        logic [1:0]         status;
    } result_t;

endpackage

// ===== rtl/thread_table_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// thread_table_scheduler_top
// Thread table with a FIFO ready queue, driven by scheduler event beats.
// ----------------------------------------------------------------------------
// Each input beat carries one event (s_tuser: action; s_tdata: target and
// exit value) and produces exactly one result beat on the m_ channel.
// Events are handled one at a time by a sequencer around four slot tables
// (state, ID, exit code, queue link), each with one write port and a
// registered read port. Create walks the state table one slot at a time,
// reading and then checking each slot, until it finds a dead slot or
// reaches the end of the table.
// The result sits in an output register: the next event is accepted while
// it waits, and a stalled receiver only holds the sequencer once a second
// result is ready.
// After reset the state table is cleared, one entry per cycle; s_tready
// stays low during that pass. The ID counter restarts at one, the queue
// is empty and no thread is current.
// ----------------------------------------------------------------------------
module thread_table_scheduler_top #(
    parameter int SLOT_COUNT = tts_pkg::SLOT_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // target[5:0], exit_value[37:6], zero pad
    input  logic [2:0]  s_tuser,  // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata   // status[1:0], current_valid[2],
                                  // current_index[8:3], switched[9],
                                  // previous_index[15:10], slot_index[21:16],
                                  // slot_id[53:22], join_code[85:54],
                                  // slot_state[87:86]
);
    import tts_pkg::*;

    logic    res_valid, res_ready;
    result_t res;
    result_t out_reg;
    logic    mvalid_reg;

    assign res_ready = !mvalid_reg || m_tready;

    tts_ctrl #(.SLOT_COUNT(SLOT_COUNT)) u_ctrl (
        .clk(aclk), .rstn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_action(s_tuser), .in_target(s_tdata[5:0]), .in_value(s_tdata[37:6]),
        .res_valid(res_valid), .res_ready(res_ready), .res(res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (res_valid) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = out_reg;

    a_no_fast_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !res_valid)
        else $error("result produced one cycle after event beat");

    a_switch_current: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (!res.switched || res.current_valid))
        else $error("switch flagged without a current thread");

    a_full_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.status == RS_FULL |-> res.slot_index == 6'd0 && res.slot_id == 32'd0)
        else $error("full table reported a slot");

    a_idle_current: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res.current_valid |-> res.current_index == 6'd0)
        else $error("current index without a current thread");

endmodule

// ===== rtl/tts_ram.sv =====
// ----------------------------------------------------------------------------
// tts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/tts_ctrl.sv =====
// ----------------------------------------------------------------------------
// tts_ctrl
// Event sequencer: reads, modifies and writes back the slot tables and
// keeps the ready queue pointers and the current thread.
// ----------------------------------------------------------------------------
module tts_ctrl #(
    parameter int SLOT_COUNT = 64
) (
    input  logic               clk,
    input  logic               rstn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         in_action,
    input  logic [5:0]         in_target,
    input  logic signed [31:0] in_value,
    output logic               res_valid,
    input  logic               res_ready,
    output tts_pkg::result_t   res
);
    import tts_pkg::*;

    localparam int IW = $clog2(SLOT_COUNT);

    state_t state_reg, state_next;

    logic [2:0]         act_reg, act_next;
    logic [5:0]         tgt_reg, tgt_next;
    logic signed [31:0] val_reg, val_next;
    logic [IW:0]        scan_reg, scan_next;
    logic [IW-1:0]      clr_reg, clr_next;
    logic [IW-1:0]      head_reg, head_next;
    logic [IW-1:0]      tail_reg, tail_next;
    logic               ne_reg, ne_next;
    logic [IW-1:0]      run_reg, run_next;
    logic               runv_reg, runv_next;
    logic [31:0]        id_reg, id_next;
    logic               wasv_reg, wasv_next;
    logic [IW-1:0]      was_reg, was_next;
    logic [1:0]         stat_reg, stat_next;
    logic               have_reg, have_next;
    logic [IW-1:0]      slot_reg, slot_next;
    logic [31:0]        sid_reg, sid_next;
    logic [31:0]        code_reg, code_next;
    logic [1:0]         sst_reg, sst_next;

    logic          st_we, id_we, ex_we, ln_we;
    logic [IW-1:0] st_wa, id_wa, ex_wa, ln_wa, st_ra;
    logic [1:0]    st_wd, st_rd;
    logic [31:0]   id_wd, id_rd, ex_wd, ex_rd;
    logic [IW-1:0] ln_wd, ln_rd;

    logic          enq;
    logic [IW-1:0] enq_slot;
    logic [IW-1:0] tgt_idx, scan_idx;
    logic          tgt_ok, scan_end, cur_live, deq_more;
    state_t        after_deq;

    assign tgt_idx   = IW'(tgt_reg);
    assign scan_idx  = scan_reg[IW-1:0];
    assign tgt_ok    = 32'(tgt_reg) < 32'(SLOT_COUNT);
    assign scan_end  = scan_reg == (IW+1)'(SLOT_COUNT);
    assign cur_live  = st_rd == SS_RUNNING || st_rd == SS_BLOCKED;
    assign deq_more  = ne_reg && head_reg != tail_reg;
    assign after_deq = (act_reg == ACT_JOIN) ? S_POST_RD : S_OUT;

    tts_ram #(.WIDTH(2), .DEPTH(SLOT_COUNT)) u_status (
        .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd)
    );
    tts_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_ident (
        .clk(clk), .we(id_we), .waddr(id_wa), .wdata(id_wd), .raddr(tgt_idx), .rdata(id_rd)
    );
    tts_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_exit (
        .clk(clk), .we(ex_we), .waddr(ex_wa), .wdata(ex_wd), .raddr(tgt_idx), .rdata(ex_rd)
    );
    tts_ram #(.WIDTH(IW), .DEPTH(SLOT_COUNT)) u_link (
        .clk(clk), .we(ln_we), .waddr(ln_wa), .wdata(ln_wd), .raddr(head_reg), .rdata(ln_rd)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_reg == IW'(SLOT_COUNT - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (in_valid) state_next = S_START;
            end
            S_START: begin
                case (act_reg)
                    ACT_CREATE: state_next = S_SCAN_RD;
                    ACT_SCHED:  state_next = runv_reg ? S_RS_RD : S_DEQ;
                    ACT_BLOCK, ACT_EXIT: state_next = runv_reg ? S_CUR_CHK : S_OUT;
                    ACT_WAKE, ACT_JOIN:  state_next = tgt_ok ? S_TGT_CHK : S_OUT;
                    default:    state_next = S_OUT;
                endcase
            end
            S_SCAN_RD:  state_next = scan_end ? S_OUT : S_SCAN_CHK;
            S_SCAN_CHK: state_next = (st_rd == SS_DEAD) ? S_OUT : S_SCAN_RD;
            S_CUR_CHK:  state_next = cur_live ? S_DEQ : S_OUT;
            S_TGT_CHK: begin
                if (act_reg == ACT_JOIN && st_rd != SS_DEAD) begin
                    state_next = runv_reg ? S_RS_RD : S_DEQ;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_RS_RD:    state_next = S_RS_CHK;
            S_RS_CHK:   state_next = S_DEQ;
            S_DEQ:      state_next = deq_more ? S_DEQ_LINK : after_deq;
            S_DEQ_LINK: state_next = after_deq;
            S_POST_RD:  state_next = S_POST_CHK;
            S_POST_CHK: state_next = S_OUT;
            S_OUT: begin
                if (res_ready) state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and table ports
    always_comb begin
        act_next  = act_reg;
        tgt_next  = tgt_reg;
        val_next  = val_reg;
        scan_next = scan_reg;
        clr_next  = clr_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        ne_next   = ne_reg;
        run_next  = run_reg;
        runv_next = runv_reg;
        id_next   = id_reg;
        wasv_next = wasv_reg;
        was_next  = was_reg;
        stat_next = stat_reg;
        have_next = have_reg;
        slot_next = slot_reg;
        sid_next  = sid_reg;
        code_next = code_reg;
        sst_next  = sst_reg;
        st_we = 1'b0; st_wa = run_reg;  st_wd = SS_DEAD;
        id_we = 1'b0; id_wa = scan_idx; id_wd = id_reg;
        ex_we = 1'b0; ex_wa = scan_idx; ex_wd = 32'd0;
        ln_we = 1'b0; ln_wa = tail_reg; ln_wd = '0;
        st_ra    = run_reg;
        enq      = 1'b0;
        enq_slot = run_reg;

        case (state_reg)
            S_CLEAR: begin
                st_we    = 1'b1;
                st_wa    = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            S_IDLE: begin
                act_next  = in_action;
                tgt_next  = in_target;
                val_next  = in_value;
                wasv_next = runv_reg;
                was_next  = run_reg;
                stat_next = RS_OK;
                have_next = 1'b0;
                slot_next = '0;
                sid_next  = '0;
                code_next = '0;
                sst_next  = SS_DEAD;
                scan_next = '0;
            end
            S_START: begin
                st_ra = (act_reg == ACT_WAKE || act_reg == ACT_JOIN) ? tgt_idx : run_reg;
                case (act_reg)
                    ACT_CREATE, ACT_SCHED: ;
                    ACT_BLOCK, ACT_EXIT: begin
                        if (!runv_reg) stat_next = RS_IGNORED;
                    end
                    ACT_WAKE, ACT_JOIN: begin
                        if (!tgt_ok) stat_next = RS_IGNORED;
                    end
                    default: stat_next = RS_IGNORED;
                endcase
            end
            S_SCAN_RD: begin
                st_ra = scan_idx;
                if (scan_end) stat_next = RS_FULL;
            end
            S_SCAN_CHK: begin
                if (st_rd == SS_DEAD) begin
                    id_we     = 1'b1;
                    ex_we     = 1'b1;
                    enq       = 1'b1;
                    enq_slot  = scan_idx;
                    id_next   = id_reg + 32'd1;
                    have_next = 1'b1;
                    slot_next = scan_idx;
                    sid_next  = id_reg;
                    sst_next  = SS_READY;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_CUR_CHK: begin
                if (cur_live) begin
                    st_we = 1'b1;
                    st_wa = run_reg;
                    if (act_reg == ACT_BLOCK) begin
                        st_wd = SS_BLOCKED;
                    end else begin
                        st_wd = SS_DEAD;
                        ex_we = 1'b1;
                        ex_wa = run_reg;
                        ex_wd = 32'(val_reg);
                    end
                end else begin
                    stat_next = RS_IGNORED;
                end
            end
            S_TGT_CHK: begin
                if (act_reg == ACT_WAKE) begin
                    if (st_rd == SS_BLOCKED) begin
                        enq       = 1'b1;
                        enq_slot  = tgt_idx;
                        have_next = 1'b1;
                        slot_next = tgt_idx;
                        sid_next  = id_rd;
                        sst_next  = SS_READY;
                    end else begin
                        stat_next = RS_IGNORED;
                    end
                end else begin
                    have_next = 1'b1;
                    slot_next = tgt_idx;
                    sid_next  = id_rd;
                    if (st_rd == SS_DEAD) begin
                        code_next = ex_rd;
                        sst_next  = SS_DEAD;
                    end else begin
                        stat_next = RS_NOTDEAD;
                    end
                end
            end
            S_RS_RD: st_ra = run_reg;
            S_RS_CHK: begin
                // requeue the current thread only while it still runs
                if (st_rd == SS_RUNNING) begin
                    enq      = 1'b1;
                    enq_slot = run_reg;
                end
            end
            S_DEQ: begin
                if (ne_reg) begin
                    st_we     = 1'b1;
                    st_wa     = head_reg;
                    st_wd     = SS_RUNNING;
                    run_next  = head_reg;
                    runv_next = 1'b1;
                    if (head_reg == tail_reg) ne_next = 1'b0;
                end
            end
            S_DEQ_LINK: head_next = ln_rd;
            S_POST_RD:  st_ra = tgt_idx;
            S_POST_CHK: sst_next = st_rd;
            S_OUT: ;
            default: ;
        endcase

        if (enq) begin
            st_we = 1'b1;
            st_wa = enq_slot;
            st_wd = SS_READY;
            if (ne_reg) begin
                ln_we = 1'b1;
                ln_wd = enq_slot;
            end else begin
                head_next = enq_slot;
            end
            tail_next = enq_slot;
            ne_next   = 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            ne_reg    <= 1'b0;
            run_reg   <= '0;
            runv_reg  <= 1'b0;
            id_reg    <= 32'd1;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            ne_reg    <= ne_next;
            run_reg   <= run_next;
            runv_reg  <= runv_next;
            id_reg    <= id_next;
        end
        act_reg  <= act_next;
        tgt_reg  <= tgt_next;
        val_reg  <= val_next;
        scan_reg <= scan_next;
        wasv_reg <= wasv_next;
        was_reg  <= was_next;
        stat_reg <= stat_next;
        have_reg <= have_next;
        slot_reg <= slot_next;
        sid_reg  <= sid_next;
        code_reg <= code_next;
        sst_reg  <= sst_next;
    end

    assign in_ready  = state_reg == S_IDLE;
    assign res_valid = state_reg == S_OUT && res_ready;

    always_comb begin
        res.status         = stat_reg;
        res.current_valid  = runv_reg;
        res.current_index  = runv_reg ? 6'(run_reg) : 6'd0;
        res.switched       = runv_reg && (!wasv_reg || was_reg != run_reg);
        res.previous_index = 6'(was_reg);
        res.slot_index     = have_reg ? 6'(slot_reg) : 6'd0;
        res.slot_id        = have_reg ? sid_reg : 32'd0;
        res.join_code      = code_reg;
        res.slot_state     = have_reg ? sst_reg : SS_DEAD;
    end

endmodule
